>>> sv/nvl_pkg.sv
// ============================================================================
// nvl_pkg: shared types and constants of the vector L2 normaliser
// Field widths, quotient unit widths and the request and response records
// passed between the top level and the quotient unit.
// ============================================================================
package nvl_pkg;

    // Widths fixed by the element and result formats.
    localparam int DATA_W  = 16;
    localparam int SUM_W   = 38;
    localparam int Q_W     = 16;
    localparam int STEP_W  = 4;

    // The quotient search works on q^2 * S against mag^2 * 2^30.
    localparam int FRAC_SHIFT = 30;
    localparam int MSQ_W      = 31;
    localparam int ACC_W      = 72;

    // Default vector capacity.
    localparam int MAX_LEN_DEF = 64;

    // Saturation limits of the Q1.15 result.
    localparam logic [Q_W-1:0] POS_LIMIT = 16'h7FFF;
    localparam logic [Q_W-1:0] NEG_LIMIT = 16'h8000;

    // Request to the quotient unit.
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] value;
        logic [SUM_W-1:0]         sum;
    } div_req_t;

    // Status and result from the quotient unit.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [Q_W-1:0]   value;
    } div_rsp_t;

endpackage

>>> sv/nvl_div.sv
// ============================================================================
// nvl_div: iterative quotient unit
// Finds the largest q with q^2 * S <= mag^2 * 2^30, one bit per cycle from
// the top bit down, then applies sign, saturation and the all-zero case.
// ============================================================================
module nvl_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  nvl_pkg::div_req_t div_req,
    output nvl_pkg::div_rsp_t div_rsp
);
    import nvl_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [Q_W-1:0]    q_reg;
    logic [ACC_W-1:0]  a_reg;
    logic [ACC_W-1:0]  c_reg;
    logic [ACC_W-1:0]  d_reg;
    logic [MSQ_W-1:0]  msq_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DATA_W-1:0] mag;
    logic [ACC_W-1:0]  cand;
    logic [ACC_W-1:0]  rhs;
    logic              fits;
    logic [Q_W-1:0]    q_sat;
    logic [Q_W-1:0]    value;

    // Magnitude of the element; the most negative code gives 2^15 unsigned.
    assign mag = div_req.value[DATA_W-1] ? DATA_W'(-div_req.value) : div_req.value;

    // A holds q^2*S, C holds (q*S) << (k+1) and D holds S << 2k, so the
    // trial square (q + 2^k)^2 * S is the sum of the three.
    assign cand = a_reg + c_reg + d_reg;
    assign rhs  = {{(ACC_W - MSQ_W - FRAC_SHIFT){1'b0}}, msq_reg, {FRAC_SHIFT{1'b0}}};
    assign fits = (cand <= rhs);

    // Search loop and start of a new quotient.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (div_req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(Q_W - 1);
            q_reg    <= '0;
            a_reg    <= '0;
            c_reg    <= '0;
            d_reg    <= ACC_W'(div_req.sum) << FRAC_SHIFT;
            msq_reg  <= MSQ_W'(mag * mag);
            neg_reg  <= div_req.value[DATA_W-1];
            zero_reg <= (div_req.sum == '0);
        end else if (busy_reg) begin
            if (fits) begin
                q_reg[step_reg] <= 1'b1;
                a_reg           <= cand;
                c_reg           <= (c_reg >> 1) + d_reg;
            end else begin
                c_reg <= c_reg >> 1;
            end
            d_reg <= d_reg >> 2;
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // Sign, saturation and the all-zero vector.
    always_comb begin
        q_sat = '0;
        value = '0;
        if (zero_reg) begin
            value = '0;
        end else if (neg_reg) begin
            q_sat = (q_reg > NEG_LIMIT) ? NEG_LIMIT : q_reg;
            value = Q_W'(0) - q_sat;
        end else begin
            q_sat = (q_reg > POS_LIMIT) ? POS_LIMIT : q_reg;
            value = q_sat;
        end
    end

    assign div_rsp.busy  = busy_reg;
    assign div_rsp.done  = done_reg;
    assign div_rsp.value = value;

endmodule

>>> sv/vector_l2_normalizer_top.sv
// Load: one element word per cycle, s_tready high whenever no burst runs.
// Burst: each result takes a memory read, a unit start and a 16-step quotient
// search in the bit-serial loop of nvl_div, then waits until the output is free;
// the next element is read only once the previous result has been emitted.
// Reset (aresetn low, synchronous) clears the count, sum, overflow flag and
// output valid; the element memory is not cleared and needs no clearing pass.
// ============================================================================
// vector_l2_normalizer_top: L2 normalisation of one vector
// Stores elements in a synchronous memory while summing their squares, then
// reads each back and emits it divided by the Euclidean norm, in Q1.15.
// ============================================================================
module vector_l2_normalizer_top #(
    parameter int MAX_LEN = nvl_pkg::MAX_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nvl_pkg::DATA_W-1:0]  s_tdata,   // [15:0] element_value
    input  logic                        s_tlast,   // is_last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nvl_pkg::Q_W-1:0]     m_tdata,   // [15:0] normalized_value
    output logic                        m_tlast,   // last_of_run
    output logic                        m_tuser    // [0] overflowed
);
    import nvl_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_START,
        ST_CALC
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              m_tvalid_reg;
    logic [Q_W-1:0]    m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic [DATA_W-1:0] mem [MAX_LEN];

    logic                     accept;
    logic                     room;
    logic                     last_idx;
    logic                     out_free;
    logic                     emit;
    logic signed [DATA_W-1:0] elem;
    logic signed [2*DATA_W-1:0] sq;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign room     = (count_reg < CNT_W'(MAX_LEN));
    assign last_idx = (idx_reg == count_reg - 1'b1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (state_reg == ST_CALC) && div_rsp.done && out_free;
    assign elem     = signed'(s_tdata);
    assign sq       = elem * elem;

    // Element memory: one write port while loading, one registered read port.
    always_ff @(posedge aclk) begin
        if (accept && room) begin
            mem[count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Quotient unit, started once the stored element has been read.
    assign div_req.start = (state_reg == ST_START);
    assign div_req.value = signed'(rd_data_reg);
    assign div_req.sum   = sum_reg;

    nvl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Sequencer: load the vector, then read, divide and emit each element.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The output word is held until taken; a new one may replace it then.
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        if (room) begin
                            count_reg <= count_reg + 1'b1;
                            sum_reg   <= sum_reg + SUM_W'($unsigned(sq));
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            idx_reg   <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    if (emit) begin
                        m_tdata_reg  <= div_rsp.value;
                        m_tlast_reg  <= last_idx;
                        m_tuser_reg  <= ovf_reg;
                        if (last_idx) begin
                            count_reg <= '0;
                            sum_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // The stored element count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("element count above capacity");

    // Every element read back during a burst lies within the stored vector.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |-> (idx_reg < count_reg))
        else $error("burst index beyond stored elements");

    // The quotient unit is never restarted while it is still searching.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |-> !div_rsp.busy)
        else $error("quotient unit started while busy");

    // Emitting the final word of a burst clears the accumulated state.
    a_burst_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && div_rsp.done && out_free && last_idx)
        |=> (count_reg == '0 && sum_reg == '0 && !ovf_reg))
        else $error("state not cleared after burst");

endmodule
